/* hdl/iso8583_field_encoder_assert.svh */
// Assertion macros shared by the checker of the field encoder.
// Each macro expands to one labelled concurrent assertion.
`ifndef ISO8583_FIELD_ENCODER_ASSERT_SVH
`define ISO8583_FIELD_ENCODER_ASSERT_SVH

// Same-cycle implication, switched off while reset is low.
`define ISOENC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is low.
`define ISOENC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also watches reset itself.
`define ISOENC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/isoenc_pkg.sv */
`timescale 1ns / 1ps
package isoenc_pkg;

    localparam int SIZE_W     = 14;
    localparam int VAL_W      = 15;   // largest counted prefix value is 2 * 9999
    localparam int POW_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [SIZE_W-1:0] C_MAX_FIELD_BYTES = 14'd9999;

    typedef enum logic [2:0] {
        CFG_LENGTH_KIND = 3'd0,
        CFG_IN_ENC      = 3'd1,
        CFG_OUT_ENC     = 3'd2,
        CFG_ATTR        = 3'd3,
        CFG_PAD_F       = 3'd4,
        CFG_FIXED_LEN   = 3'd5
    } t_cfg_idx;

    localparam logic [1:0] ENC_ASCII = 2'd0;
    localparam logic [1:0] ENC_BCD   = 2'd1;
    localparam logic [1:0] ENC_BIN   = 2'd2;

    localparam logic [1:0] ATTR_NUM   = 2'd0;
    localparam logic [1:0] ATTR_BIN   = 2'd1;
    localparam logic [1:0] ATTR_OTHER = 2'd2;

    localparam logic [2:0] LK_FIXED  = 3'd0;
    localparam logic [2:0] LK_LLLLLL = 3'd5;

    localparam logic [7:0] CHR_ZERO     = 8'h30;
    localparam logic [7:0] CHR_NINE     = 8'h39;
    localparam logic [7:0] CHR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHR_UPPER_F  = 8'h46;
    localparam logic [7:0] CHR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHR_LOWER_F  = 8'h66;
    localparam logic [7:0] CHR_HEX_BASE = 8'h37;  // 'A' - 10
    localparam logic [7:0] CHR_LOW_BASE = 8'h57;  // 'a' - 10
    localparam logic [3:0] NIB_F        = 4'hF;

    typedef enum logic [1:0] {
        MODE_COPY   = 2'd0,
        MODE_PACK   = 2'd1,
        MODE_UNPACK = 2'd2,
        MODE_BAD    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_LENGTH   = 2'd1,
        ERR_PAIR     = 2'd2,
        ERR_OVERFLOW = 2'd3
    } t_err;

    typedef struct packed {
        logic [2:0]        length_kind;
        logic [1:0]        in_enc;
        logic [1:0]        out_enc;
        logic [1:0]        attr;
        logic              pad_f;
        logic [SIZE_W-1:0] fixed_len;
    } t_cfg;

    typedef struct packed {
        logic [2:0] count;
        logic       overflow;
        logic [7:0] data;
    } t_pre_info;

    typedef struct packed {
        logic       skip;
        logic [1:0] count;
        logic [7:0] data;
        logic       last;
    } t_data_info;

    typedef struct packed {
        logic [3:0]       d;
        logic [VAL_W-1:0] rem;
    } t_digit;

    function automatic t_mode pair_mode(input t_cfg c);
        t_mode m;
        if (c.in_enc == ENC_ASCII && c.out_enc == ENC_BCD) begin
            m = MODE_PACK;
        end else if (c.in_enc == ENC_BCD && c.out_enc == ENC_ASCII) begin
            m = MODE_UNPACK;
        end else if (c.in_enc == c.out_enc && c.in_enc <= ENC_BIN) begin
            m = MODE_COPY;
        end else begin
            m = MODE_BAD;
        end
        return m;
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if (c >= CHR_ZERO && c <= CHR_NINE) begin
            v = 4'(c - CHR_ZERO);
        end else if (c >= CHR_UPPER_A && c <= CHR_UPPER_F) begin
            v = 4'(c - CHR_HEX_BASE);
        end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_F) begin
            v = 4'(c - CHR_LOW_BASE);
        end else begin
            v = c[3:0];
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? CHR_ZERO + {4'd0, n} : CHR_HEX_BASE + {4'd0, n};
    endfunction

    function automatic logic [POW_W-1:0] pow10(input logic [2:0] i);
        logic [POW_W-1:0] p;
        case (i)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd0;
        endcase
        return p;
    endfunction

    // Digit count of the length prefix for a clamped kind.
    function automatic logic [2:0] prefix_digits(input logic [2:0] kind, input logic bcd);
        logic [2:0] d;
        if (kind == LK_FIXED) begin
            d = 3'd0;
        end else if (bcd) begin
            d = {kind[2:1] + 2'd1, 1'b0} - (kind == 3'd2 ? 3'd0 : 3'd0);
            case (kind)
                3'd1:    d = 3'd2;
                3'd2:    d = 3'd4;
                3'd3:    d = 3'd4;
                default: d = 3'd6;
            endcase
        end else begin
            d = kind + 3'd1;
        end
        return d;
    endfunction

    // One decimal digit of rem at weight 10^w; rem stays below 10 * 10^w.
    function automatic t_digit digit_step(input logic [VAL_W-1:0] rem, input logic [2:0] w);
        logic [POW_W-1:0] p;
        logic [POW_W-1:0] sub;
        logic [POW_W-1:0] wide;
        t_digit r;
        p     = pow10(w);
        sub   = '0;
        wide  = {{(POW_W-VAL_W){1'b0}}, rem};
        r.d   = '0;
        for (int j = 1; j <= 9; j++) begin
            if (wide >= POW_W'(j) * p) begin
                r.d = 4'(j);
                sub = POW_W'(j) * p;
            end
        end
        r.rem = VAL_W'(wide - sub);
        return r;
    endfunction

endpackage

/* hdl/isoenc_cfg.sv */
`timescale 1ns / 1ps
module isoenc_cfg import isoenc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.length_kind <= LK_FIXED;
            r_cfg.in_enc      <= ENC_ASCII;
            r_cfg.out_enc     <= ENC_ASCII;
            r_cfg.attr        <= ATTR_OTHER;
            r_cfg.pad_f       <= 1'b0;
            r_cfg.fixed_len   <= '0;
        end else if (i_we) begin
            unique case (t_cfg_idx'(i_idx))
                CFG_LENGTH_KIND: r_cfg.length_kind <= i_data[2:0];
                CFG_IN_ENC:      r_cfg.in_enc      <= i_data[1:0];
                CFG_OUT_ENC:     r_cfg.out_enc     <= i_data[1:0];
                CFG_ATTR:        r_cfg.attr        <= i_data[1:0];
                CFG_PAD_F:       r_cfg.pad_f       <= i_data[0];
                CFG_FIXED_LEN:   r_cfg.fixed_len   <= i_data[SIZE_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/isoenc_prefix.sv */
`timescale 1ns / 1ps
module isoenc_prefix import isoenc_pkg::*; (
    input  logic             i_clk,
    input  t_cfg             i_cfg,
    input  logic [VAL_W-1:0] i_val,
    input  logic [2:0]       i_idx,
    input  logic             i_step,
    output t_pre_info        o_info
);

    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] n_rem;
    logic [VAL_W-1:0] rem;
    logic [2:0]       kind;
    logic             bcd;
    logic [2:0]       d;
    logic [2:0]       w_asc;
    logic [2:0]       w_hi;
    t_digit           dg_asc;
    t_digit           dg_hi;
    t_digit           dg_lo;

    always_comb begin
        kind  = (i_cfg.length_kind > LK_LLLLLL) ? LK_LLLLLL : i_cfg.length_kind;
        bcd   = (i_cfg.out_enc == ENC_BCD);
        d     = prefix_digits(kind, bcd);
        // restart from the full value on the first prefix byte
        rem   = (i_idx == 3'd0) ? i_val : r_rem;
        w_asc = d - 3'd1 - i_idx;
        w_hi  = d - 3'd1 - {i_idx[1:0], 1'b0};

        dg_asc = digit_step(rem, w_asc);
        dg_hi  = digit_step(rem, w_hi);
        dg_lo  = digit_step(dg_hi.rem, w_hi - 3'd1);

        o_info.count    = bcd ? {1'b0, d[2:1]} : d;
        o_info.overflow = (kind != LK_FIXED) &&
                          ({{(POW_W-VAL_W){1'b0}}, i_val} >= pow10(d));
        if (bcd) begin
            o_info.data = {dg_hi.d, dg_lo.d};
            n_rem       = dg_lo.rem;
        end else begin
            o_info.data = CHR_ZERO | {4'd0, dg_asc.d};
            n_rem       = dg_asc.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_rem <= n_rem;
        end
    end

endmodule

/* hdl/isoenc_data.sv */
`timescale 1ns / 1ps
module isoenc_data import isoenc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_mode             i_mode,
    input  logic [7:0]        i_byte,
    input  logic              i_first,
    input  logic [SIZE_W-1:0] i_size,
    input  logic              i_idx,
    input  t_err              i_err,
    input  logic              i_commit,
    output t_data_info        o_info
);

    logic [SIZE_W-1:0] r_seen;
    logic [SIZE_W-1:0] r_expected;
    logic [3:0]        r_held;
    logic              r_pending;
    logic              r_failed;

    logic [SIZE_W-1:0] n_seen;
    logic [SIZE_W-1:0] n_expected;
    logic [3:0]        n_held;
    logic              n_pending;
    logic              n_failed;

    logic              init_pend;
    logic              pend_eff;
    logic [3:0]        held_eff;
    logic [SIZE_W-1:0] seen_inc;
    logic [SIZE_W-1:0] exp_eff;
    logic              last;
    logic [3:0]        nib;

    always_comb begin
        init_pend = (i_mode == MODE_PACK) && i_size[0] && !i_cfg.pad_f &&
                    (i_cfg.attr == ATTR_NUM);
        pend_eff  = i_first ? init_pend : r_pending;
        held_eff  = i_first ? 4'd0 : r_held;
        seen_inc  = (i_first ? '0 : r_seen) + SIZE_W'(1);
        exp_eff   = i_first ? i_size : r_expected;
        last      = (seen_inc >= exp_eff);
        nib       = hex_value(i_byte);

        o_info.skip = !i_first && (r_failed || (r_seen >= r_expected));
        case (i_mode)
            MODE_COPY: begin
                o_info.count = 2'd1;
                o_info.data  = i_byte;
                o_info.last  = last;
            end
            MODE_UNPACK: begin
                o_info.count = 2'd2;
                o_info.data  = i_idx ? hex_char(i_byte[3:0]) : hex_char(i_byte[7:4]);
                o_info.last  = i_idx & last;
            end
            MODE_PACK: begin
                o_info.count = (pend_eff || last) ? 2'd1 : 2'd0;
                o_info.data  = pend_eff ? {held_eff, nib} :
                               {nib, (i_cfg.pad_f ? NIB_F : 4'd0)};
                o_info.last  = last;
            end
            default: begin
                o_info.count = 2'd0;
                o_info.data  = '0;
                o_info.last  = 1'b0;
            end
        endcase

        n_seen     = r_seen;
        n_expected = r_expected;
        n_held     = r_held;
        n_pending  = r_pending;
        n_failed   = r_failed;
        if (i_commit) begin
            if (i_first) begin
                n_expected = i_size;
            end
            if (i_err != ERR_NONE) begin
                n_failed  = 1'b1;
                n_pending = 1'b0;
                if (i_first) begin
                    n_seen = SIZE_W'(1);
                    n_held = 4'd0;
                end
            end else if (!o_info.skip) begin
                n_failed  = 1'b0;
                n_seen    = seen_inc;
                n_held    = held_eff;
                n_pending = pend_eff;
                if (i_mode == MODE_PACK) begin
                    if (pend_eff || last) begin
                        n_pending = 1'b0;
                    end else begin
                        n_held    = nib;
                        n_pending = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_expected <= '0;
            r_held     <= '0;
            r_pending  <= 1'b0;
            r_failed   <= 1'b0;
        end else begin
            r_seen     <= n_seen;
            r_expected <= n_expected;
            r_held     <= n_held;
            r_pending  <= n_pending;
            r_failed   <= n_failed;
        end
    end

endmodule

/* hdl/iso8583_field_encoder.sv */
`timescale 1ns / 1ps
// Channel   Dir  tdata (low bit up)            tuser / tlast
// s_axis    in   data_byte[7:0], size[21:8]    tuser[0] first_byte
// m_axis    out  out_byte[7:0]                 tuser[0] is_prefix, [2:1] error_code,
//                                              tlast last_of_field
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data (write only)
//
// Each input beat occupies the work stage until it has yielded all its output beats:
// one for copy or error beats, one or none for packed beats, two when unpacking BCD, and
// up to eight on the first beat of a variable field (one to six prefix bytes, one prefix
// byte per cycle while m_axis does not stall). Beats with no output do not wait on m_axis.
// Reset is synchronous and active low; it clears the control registers and the field state.
// A stall on m_axis holds the output register and then the work stage; the input
// register is free again in the cycle its last output beat moves into the output register.
module iso8583_field_encoder import isoenc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // data_byte, field_size, zero fill
    input  logic [0:0]            s_axis_tuser,   // first_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // out_byte
    output logic                  m_axis_tlast,   // last_of_field
    output logic [2:0]            m_axis_tuser    // is_prefix, error_code
);

    t_cfg       cfg;
    t_mode      mode;
    t_pre_info  pre;
    t_data_info dat;

    // input register (work stage)
    logic              r_busy;
    logic [2:0]        r_phase;
    logic [7:0]        r_byte;
    logic              r_first;
    logic [SIZE_W-1:0] r_size;
    logic [VAL_W-1:0]  r_val;

    // output register
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_prefix;
    logic              r_out_last;
    t_err              r_out_err;

    logic [SIZE_W-1:0] in_size;
    logic [SIZE_W-1:0] n_size;
    logic [VAL_W-1:0]  n_enc;
    logic [VAL_W-1:0]  n_val;
    logic              accept;

    t_err              err;
    logic [2:0]        np_eff;
    logic [2:0]        data_pos;
    logic [3:0]        ntot;
    logic              in_pre;
    logic              last_idx;
    logic              out_free;
    logic              emit;
    logic              done;
    logic              pre_step;
    logic [7:0]        res_byte;
    logic              res_prefix;
    logic              res_last;
    t_err              res_err;

    isoenc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign mode = pair_mode(cfg);

    // Clamp the size and work out the counted prefix value as the beat comes in.
    always_comb begin
        in_size = s_axis_tdata[8 +: SIZE_W];
        if (in_size == '0) begin
            n_size = SIZE_W'(1);
        end else if (in_size > C_MAX_FIELD_BYTES) begin
            n_size = C_MAX_FIELD_BYTES;
        end else begin
            n_size = in_size;
        end
        case (mode)
            MODE_PACK:   n_enc = VAL_W'(({1'b0, n_size} + 15'd1) >> 1);
            MODE_UNPACK: n_enc = {n_size, 1'b0};
            default:     n_enc = {1'b0, n_size};
        endcase
        // BCD prefixes count nibbles unless the field is binary
        if (cfg.out_enc == ENC_BCD && cfg.attr != ATTR_BIN) begin
            n_val = {n_enc[VAL_W-2:0], 1'b0};
        end else begin
            n_val = n_enc;
        end
    end

    isoenc_prefix u_prefix (
        .i_clk  (i_clk),
        .i_cfg  (cfg),
        .i_val  (r_val),
        .i_idx  (r_phase),
        .i_step (pre_step),
        .o_info (pre)
    );

    isoenc_data u_data (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_mode   (mode),
        .i_byte   (r_byte),
        .i_first  (r_first),
        .i_size   (r_size),
        .i_idx    (data_pos[0]),
        .i_err    (err),
        .i_commit (done),
        .o_info   (dat)
    );

    always_comb begin
        // checks in order: fixed length, encoding pair, prefix overflow
        if (r_first) begin
            if (cfg.length_kind == LK_FIXED && r_size != cfg.fixed_len) begin
                err = ERR_LENGTH;
            end else if (mode == MODE_BAD) begin
                err = ERR_PAIR;
            end else if (pre.overflow) begin
                err = ERR_OVERFLOW;
            end else begin
                err = ERR_NONE;
            end
        end else begin
            err = (mode == MODE_BAD) ? ERR_PAIR : ERR_NONE;
        end

        np_eff   = r_first ? pre.count : 3'd0;
        data_pos = r_phase - np_eff;
        if (dat.skip) begin
            ntot = 4'd0;
        end else if (err != ERR_NONE) begin
            ntot = 4'd1;
        end else begin
            ntot = {1'b0, np_eff} + {2'd0, dat.count};
        end
        in_pre   = (r_phase < np_eff);
        last_idx = ({1'b0, r_phase} == ntot - 4'd1);

        out_free = !r_out_valid || m_axis_tready;
        emit     = r_busy && out_free && (ntot != 4'd0);
        done     = r_busy && ((ntot == 4'd0) || (out_free && last_idx));
        pre_step = emit && in_pre && (err == ERR_NONE);

        if (err != ERR_NONE) begin
            res_byte   = '0;
            res_prefix = 1'b0;
            res_last   = 1'b1;
            res_err    = err;
        end else if (in_pre) begin
            res_byte   = pre.data;
            res_prefix = 1'b1;
            res_last   = 1'b0;
            res_err    = ERR_NONE;
        end else begin
            res_byte   = dat.data;
            res_prefix = 1'b0;
            res_last   = dat.last;
            res_err    = ERR_NONE;
        end
    end

    // Take a new beat when the stage is empty or is done with its beat this cycle.
    assign s_axis_tready = !r_busy || done;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_phase <= '0;
            end else if (emit) begin
                r_phase <= r_phase + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte  <= s_axis_tdata[7:0];
            r_first <= s_axis_tuser[0];
            r_size  <= n_size;
            r_val   <= n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte   <= res_byte;
            r_out_prefix <= res_prefix;
            r_out_last   <= res_last;
            r_out_err    <= res_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out_err, r_out_prefix};

endmodule

/* hdl/isoenc_checker.sv */
`timescale 1ns / 1ps
`include "iso8583_field_encoder_assert.svh"
module isoenc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [2:0]  m_axis_tuser
);

    // an error beat is a bare terminator: zero byte, no prefix flag, closes the field
    `ISOENC_ASSERT_IMP(a_err_beat, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser[2:1] != 2'd0), (m_axis_tdata == 8'd0) && !m_axis_tuser[0] && m_axis_tlast, "error beat malformed")

    // prefix bytes never close a field and never carry an error
    `ISOENC_ASSERT_IMP(a_prefix_beat, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], !m_axis_tlast && (m_axis_tuser[2:1] == 2'd0), "prefix beat marked last or errored")

    // a stalled output beat holds
    `ISOENC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled output beat changed")

    // nothing leaves straight after a reset edge
    `ISOENC_ASSERT_NXT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !m_axis_tvalid, "output valid after reset")

endmodule

bind iso8583_field_encoder isoenc_checker u_isoenc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Block-level bench for the field encoder. Field bytes go in over s_axis,
// the encoded beats are checked on m_axis against a predictor that tracks
// the register settings and the open field.
module tb_top;
    import isoenc_pkg::*;

    localparam int RANDOM_ITEMS = 405;   // directed part adds about 25
    localparam int SETTLE       = 12;    // worst first beat plus pipeline
    localparam int QUIET_LIMIT  = 4000;

    // One expected output beat.
    typedef struct {
        logic [7:0] out_byte;
        logic       is_prefix;
        logic       last;
        t_err       code;
    } t_enc_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata = '0;   // data_byte, field_size, zero fill
    logic [0:0]            s_axis_tuser = '0;   // first_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;        // out_byte
    logic                  m_axis_tlast;        // last_of_field
    logic [2:0]            m_axis_tuser;        // is_prefix, error_code

    // Predictor state: register copy and the open field.
    t_cfg        enc_cfg;
    int unsigned bytes_in_field;
    int unsigned field_len;
    logic [3:0]  held_nib;
    logic        nib_waiting;
    logic        field_dead;

    t_enc_beat   expected_beats[$];

    int unsigned send_gap_pct = 14;
    int unsigned recv_stall_pct = 46;
    int unsigned beats_sent = 0;
    int unsigned beats_checked = 0;
    int unsigned error_beats = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    iso8583_field_encoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Conversion chosen by the source and wire encodings.
    function automatic t_mode route_of(input logic [1:0] src, input logic [1:0] dst);
        t_mode m;
        case ({src, dst})
            {ENC_ASCII, ENC_BCD}:   m = MODE_PACK;
            {ENC_BCD, ENC_ASCII}:   m = MODE_UNPACK;
            {ENC_ASCII, ENC_ASCII},
            {ENC_BCD, ENC_BCD},
            {ENC_BIN, ENC_BIN}:     m = MODE_COPY;
            default:                m = MODE_BAD;
        endcase
        return m;
    endfunction

    // ASCII hex digit to nibble; anything else keeps its low four bits.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= CHR_ZERO && c <= CHR_NINE) begin
            return c[3:0];
        end else if ((c >= CHR_UPPER_A && c <= CHR_UPPER_F) ||
                     (c >= CHR_LOWER_A && c <= CHR_LOWER_F)) begin
            return c[3:0] + 4'd9;
        end
        return c[3:0];
    endfunction

    function automatic logic [7:0] char_of(input logic [3:0] n);
        return (n < 4'd10) ? CHR_ZERO + 8'(n) : CHR_UPPER_A + 8'(n - 4'd10);
    endfunction

    task automatic push_beat(input logic [7:0] b, input logic pre, input logic last,
                             input t_err code);
        t_enc_beat e;
        e.out_byte  = b;
        e.is_prefix = pre;
        e.last      = last;
        e.code      = code;
        expected_beats.push_back(e);
    endtask

    // Work out the output beats of one accepted field byte.
    task automatic encode_byte(input logic [7:0] b, input logic is_first,
                               input logic [SIZE_W-1:0] size_in);
        int unsigned kind;
        int unsigned size;
        int unsigned enc;
        int unsigned val;
        int unsigned ndig;
        int unsigned lim;
        int unsigned dig[6];
        t_mode       mode;
        t_err        err;
        logic        bcd_pre;
        logic        last;
        logic [3:0]  nib;

        kind = 32'((enc_cfg.length_kind > LK_LLLLLL) ? LK_LLLLLL : enc_cfg.length_kind);
        mode = route_of(enc_cfg.in_enc, enc_cfg.out_enc);

        if (is_first) begin
            size = 32'(size_in);
            if (size == 0) size = 1;
            if (size > C_MAX_FIELD_BYTES) size = 32'(C_MAX_FIELD_BYTES);
            field_len      = size;
            bytes_in_field = 0;
            field_dead     = 1'b0;
            nib_waiting    = 1'b0;
            held_nib       = 4'd0;
            err            = ERR_NONE;
            ndig           = 0;
            bcd_pre        = (enc_cfg.out_enc == ENC_BCD);
            foreach (dig[i]) dig[i] = 0;

            // Length check, then the encoding pair, then prefix overflow.
            if (kind == LK_FIXED && size != enc_cfg.fixed_len) begin
                err = ERR_LENGTH;
            end else if (mode == MODE_BAD) begin
                err = ERR_PAIR;
            end else if (kind != LK_FIXED) begin
                enc = (mode == MODE_PACK) ? (size + 1) / 2 :
                      (mode == MODE_UNPACK) ? size * 2 : size;
                if (bcd_pre) begin
                    ndig = (kind == 1) ? 2 : (kind <= 3) ? 4 : 6;
                    val  = (enc_cfg.attr == ATTR_BIN) ? enc : enc * 2;
                end else begin
                    ndig = kind + 1;
                    val  = enc;
                end
                lim = 1;
                for (int i = 0; i < ndig; i++) lim *= 10;
                if (val >= lim) begin
                    err = ERR_OVERFLOW;
                end else begin
                    for (int i = ndig - 1; i >= 0; i--) begin
                        dig[i] = val % 10;
                        val   /= 10;
                    end
                end
            end

            if (err != ERR_NONE) begin
                field_dead     = 1'b1;
                bytes_in_field = 1;
                push_beat(8'h00, 1'b0, 1'b1, err);
                return;
            end

            if (bcd_pre) begin
                for (int i = 0; i + 1 < ndig; i += 2)
                    push_beat({dig[i][3:0], dig[i+1][3:0]}, 1'b1, 1'b0, ERR_NONE);
            end else begin
                for (int i = 0; i < ndig; i++)
                    push_beat(CHR_ZERO + 8'(dig[i]), 1'b1, 1'b0, ERR_NONE);
            end
            // Odd numeric field without F padding: lead with a zero nibble.
            if (mode == MODE_PACK && size[0] && !enc_cfg.pad_f && enc_cfg.attr == ATTR_NUM) begin
                held_nib    = 4'd0;
                nib_waiting = 1'b1;
            end
        end else begin
            if (field_dead || bytes_in_field >= field_len) return;
            // Registers are live: a pair gone bad mid-field kills the field.
            if (mode == MODE_BAD) begin
                field_dead  = 1'b1;
                nib_waiting = 1'b0;
                push_beat(8'h00, 1'b0, 1'b1, ERR_PAIR);
                return;
            end
        end

        bytes_in_field++;
        last = (bytes_in_field >= field_len);

        case (mode)
            MODE_COPY: begin
                push_beat(b, 1'b0, last, ERR_NONE);
            end
            MODE_UNPACK: begin
                push_beat(char_of(b[7:4]), 1'b0, 1'b0, ERR_NONE);
                push_beat(char_of(b[3:0]), 1'b0, last, ERR_NONE);
            end
            default: begin
                nib = nibble_of(b);
                if (nib_waiting) begin
                    push_beat({held_nib, nib}, 1'b0, last, ERR_NONE);
                    nib_waiting = 1'b0;
                end else if (last) begin
                    push_beat({nib, enc_cfg.pad_f ? NIB_F : 4'h0}, 1'b0, 1'b1, ERR_NONE);
                end else begin
                    held_nib    = nib;
                    nib_waiting = 1'b1;
                end
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Output check: every m_axis beat against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : check_beat
        t_enc_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_checked++;
            if (expected_beats.size() == 0) begin
                mismatches++;
                $error("unexpected output beat, out_byte %h", m_axis_tdata);
            end else begin
                want = expected_beats.pop_front();
                if (want.code != ERR_NONE) error_beats++;
                if (m_axis_tdata !== want.out_byte) begin
                    mismatches++;
                    $error("out_byte: expected %h, got %h", want.out_byte, m_axis_tdata);
                end
                if (m_axis_tuser[0] !== want.is_prefix) begin
                    mismatches++;
                    $error("is_prefix: expected %b, got %b", want.is_prefix, m_axis_tuser[0]);
                end
                if (m_axis_tlast !== want.last) begin
                    mismatches++;
                    $error("last_of_field: expected %b, got %b", want.last, m_axis_tlast);
                end
                if (m_axis_tuser[2:1] !== want.code) begin
                    mismatches++;
                    $error("error_code: expected %0d, got %0d", want.code, m_axis_tuser[2:1]);
                end
            end
        end
    end

    // Watchdog: give up after a long stretch with no beat moving on any port.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic t_cfg setting(input logic [2:0] lk, input logic [1:0] src,
                                     input logic [1:0] dst, input logic [1:0] attr,
                                     input logic pad, input logic [SIZE_W-1:0] fixed);
        t_cfg c;
        c.length_kind = lk;
        c.in_enc      = src;
        c.out_enc     = dst;
        c.attr        = attr;
        c.pad_f       = pad;
        c.fixed_len   = fixed;
        return c;
    endfunction

    // Write all six registers back to back; only called with the block idle.
    task automatic write_config(input t_cfg c);
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] val;
        idx = CFG_LENGTH_KIND;
        repeat (6) begin
            case (idx)
                CFG_LENGTH_KIND: val = CFG_DATA_W'(c.length_kind);
                CFG_IN_ENC:      val = CFG_DATA_W'(c.in_enc);
                CFG_OUT_ENC:     val = CFG_DATA_W'(c.out_enc);
                CFG_ATTR:        val = CFG_DATA_W'(c.attr);
                CFG_PAD_F:       val = CFG_DATA_W'(c.pad_f);
                default:         val = c.fixed_len;
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= val;
            @(posedge i_clk);
            idx = idx.next();
        end
        i_cfg_we <= 1'b0;
        enc_cfg = c;
    endtask

    // Offer one byte; hold it until the block takes it, then predict.
    task automatic send_byte(input logic [7:0] b, input logic is_first,
                             input logic [SIZE_W-1:0] size);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, size, b};
        s_axis_tuser  <= is_first;
        do @(posedge i_clk); while (!s_axis_tready);
        encode_byte(b, is_first, size);
        beats_sent++;
    endtask

    // Mostly hex digits when packing, any byte otherwise.
    function automatic logic [7:0] pick_data();
        if (route_of(enc_cfg.in_enc, enc_cfg.out_enc) == MODE_PACK &&
            $urandom_range(99) < 85) begin
            case ($urandom_range(0, 2))
                0:       return CHR_ZERO + 8'($urandom_range(0, 9));
                1:       return CHR_UPPER_A + 8'($urandom_range(0, 5));
                default: return CHR_LOWER_A + 8'($urandom_range(0, 5));
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // First byte carries the size; the rest carry noise in the size bits.
    task automatic send_field(input int unsigned size, input int unsigned nbytes);
        send_byte(pick_data(), 1'b1, SIZE_W'(size));
        repeat (nbytes - 1)
            send_byte(pick_data(), 1'b0, SIZE_W'($urandom_range(0, 16383)));
    endtask

    // Stop sending and hold until every expected beat is out, then let
    // any byte that produced nothing clear the pipeline.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Fixed field copied through, a stray byte, then a length mismatch.
    task automatic test_fixed_copy();
        write_config(setting(LK_FIXED, ENC_BIN, ENC_BIN, ATTR_OTHER, 1'b0, 14'd3));
        send_byte(8'h00, 1'b1, 14'd3);
        send_byte(8'hFF, 1'b0, 14'd0);
        send_byte(8'hA5, 1'b0, 14'h3FFF);
        send_byte(8'h5A, 1'b0, 14'd7);      // no field open: dropped
        send_byte(8'h11, 1'b1, 14'd2);      // 2 against 3: length error
        send_byte(8'h22, 1'b0, 14'd2);      // rest of a failed field: dropped
        drain_results();
    endtask

    // ASCII to binary is not a supported conversion.
    task automatic test_pair_rejects();
        write_config(setting(3'd1, ENC_ASCII, ENC_BIN, ATTR_OTHER, 1'b0, 14'd0));
        send_byte(8'h41, 1'b1, 14'd4);
        drain_results();
    endtask

    // Registers change while a field is open; the pair turns bad.
    task automatic test_live_registers();
        write_config(setting(3'd1, ENC_ASCII, ENC_ASCII, ATTR_OTHER, 1'b0, 14'd0));
        send_byte(8'h78, 1'b1, 14'd3);
        drain_results();
        write_config(setting(3'd1, 2'd3, ENC_ASCII, ATTR_OTHER, 1'b0, 14'd0));
        send_byte(8'h79, 1'b0, 14'd0);
        send_byte(8'h7A, 1'b0, 14'd0);
        drain_results();
    endtask

    // ASCII to BCD: numeric leading zero, F padding, trailing zero nibble,
    // and a held nibble thrown away by an early new field.
    task automatic test_bcd_pack();
        write_config(setting(3'd1, ENC_ASCII, ENC_BCD, ATTR_NUM, 1'b0, 14'd0));
        send_byte(8'h61, 1'b1, 14'd3);
        send_byte(8'h39, 1'b0, 14'd0);
        send_byte(8'h46, 1'b0, 14'd0);
        drain_results();
        write_config(setting(LK_FIXED, ENC_ASCII, ENC_BCD, ATTR_OTHER, 1'b1, 14'd1));
        send_byte(8'h5A, 1'b1, 14'd1);
        drain_results();
        write_config(setting(3'd1, ENC_ASCII, ENC_BCD, ATTR_OTHER, 1'b0, 14'd1));
        send_byte(8'h41, 1'b1, 14'd4);
        send_byte(8'h37, 1'b1, 14'd1);
        drain_results();
    endtask

    // BCD to ASCII with the widest prefix, out-of-range kind and attribute.
    task automatic test_bcd_unpack();
        write_config(setting(3'd7, ENC_BCD, ENC_ASCII, 2'd3, 1'b0, 14'd0));
        send_byte(8'h9F, 1'b1, 14'd2);
        send_byte(8'h3C, 1'b0, 14'd0);
        drain_results();
    endtask

    // Prefix overflow, size zero, size saturation, BCD byte-count prefix,
    // and the largest fixed field.
    task automatic test_prefix_limits();
        write_config(setting(3'd1, ENC_ASCII, ENC_ASCII, ATTR_OTHER, 1'b0, 14'd0));
        send_byte(8'h30, 1'b1, 14'd100);
        send_byte(8'h31, 1'b1, 14'd0);
        drain_results();
        write_config(setting(3'd3, ENC_BIN, ENC_BIN, ATTR_OTHER, 1'b0, 14'd0));
        send_byte(8'hC3, 1'b1, 14'h3FFF);
        send_byte(8'h3C, 1'b1, 14'd1);      // abandons the saturated field
        drain_results();
        write_config(setting(3'd2, ENC_BCD, ENC_BCD, ATTR_BIN, 1'b0, 14'd0));
        send_byte(8'h12, 1'b1, 14'd1);
        drain_results();
        write_config(setting(LK_FIXED, ENC_ASCII, ENC_ASCII, ATTR_NUM, 1'b0, 14'd9999));
        send_byte(8'h80, 1'b1, 14'd9999);
        send_byte(8'h7F, 1'b0, 14'd0);
        drain_results();
    endtask

    function automatic t_cfg random_setting();
        t_cfg c;
        c.length_kind = ($urandom_range(99) < 25) ? LK_FIXED : 3'($urandom_range(1, 7));
        if ($urandom_range(99) < 80) begin
            case ($urandom_range(0, 6))
                0:       begin c.in_enc = ENC_ASCII; c.out_enc = ENC_ASCII; end
                1:       begin c.in_enc = ENC_BCD;   c.out_enc = ENC_BCD;   end
                2:       begin c.in_enc = ENC_BIN;   c.out_enc = ENC_BIN;   end
                3, 4:    begin c.in_enc = ENC_ASCII; c.out_enc = ENC_BCD;   end
                default: begin c.in_enc = ENC_BCD;   c.out_enc = ENC_ASCII; end
            endcase
        end else begin
            c.in_enc  = 2'($urandom_range(0, 3));
            c.out_enc = 2'($urandom_range(0, 3));
        end
        c.attr  = 2'($urandom_range(0, 3));
        c.pad_f = 1'($urandom_range(0, 1));
        if ($urandom_range(99) < 85) begin
            c.fixed_len = SIZE_W'($urandom_range(1, 8));
        end else begin
            case ($urandom_range(0, 3))
                0:       c.fixed_len = 14'd0;
                1:       c.fixed_len = C_MAX_FIELD_BYTES;
                2:       c.fixed_len = 14'h3FFF;
                default: c.fixed_len = SIZE_W'($urandom_range(0, 16383));
            endcase
        end
        return c;
    endfunction

    // Random settings, each followed by a handful of fields: mostly whole
    // fields of matching size, some cut short, oversized or size zero,
    // with stray bytes in between. Idling pattern steps through the run.
    task automatic test_random_fields();
        int unsigned counted;
        int unsigned pick;
        int unsigned size;
        int unsigned nbytes;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted >= 2 * RANDOM_ITEMS / 3) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end else if (counted >= RANDOM_ITEMS / 3) begin
                send_gap_pct   = 46;
                recv_stall_pct = 14;
            end
            write_config(random_setting());
            repeat ($urandom_range(3, 8)) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    size   = $urandom_range(10, 16383);
                    nbytes = $urandom_range(1, 4);
                end else if (pick < 12) begin
                    size   = 0;
                    nbytes = 1;
                end else begin
                    if (enc_cfg.length_kind == LK_FIXED && $urandom_range(99) < 85)
                        size = 32'(enc_cfg.fixed_len);
                    else
                        size = $urandom_range(1, 8);
                    nbytes = (size > 12 || size == 0) ? $urandom_range(1, 4) : size;
                    if ($urandom_range(99) < 10) nbytes = $urandom_range(1, nbytes);
                end
                send_field(size, nbytes);
                counted += nbytes;
                // Stray bytes: ignored once the field is closed, so not counted.
                if ($urandom_range(99) < 10)
                    repeat ($urandom_range(1, 2))
                        send_byte(8'($urandom_range(0, 255)), 1'b0,
                                  SIZE_W'($urandom_range(0, 16383)));
            end
            drain_results();
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        enc_cfg        = setting(LK_FIXED, ENC_ASCII, ENC_ASCII, ATTR_OTHER, 1'b0, 14'd0);
        bytes_in_field = 0;
        field_len      = 0;
        held_nib       = 4'd0;
        nib_waiting    = 1'b0;
        field_dead     = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fixed_copy();
        test_pair_rejects();
        test_live_registers();
        test_bcd_pack();
        test_bcd_unpack();
        test_prefix_limits();
        test_random_fields();

        drain_results();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d field bytes, checked %0d encoded beats (%0d of them errors),",
                 beats_sent, beats_checked, error_beats);
        $display("over copy, BCD pack/unpack, all prefix kinds and mid-field changes.");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
